// ----- rtl/linked_multi_queue_manager_core_assert.svh -----
// Assertion macros shared by the queue manager modules.
// Both expect clk and rst_n in scope.
`ifndef LINKED_MULTI_QUEUE_MANAGER_CORE_ASSERT_SVH
`define LINKED_MULTI_QUEUE_MANAGER_CORE_ASSERT_SVH

// Plain property, checked at every rising clock edge outside reset
`define LMQM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle implies consequent on the next cycle
`define LMQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lmqm_pkg.sv -----
package lmqm_pkg;

  // Port field widths
  localparam int MODE_W     = 3;
  localparam int QID_W      = 6;
  localparam int VAL_W      = 32;
  localparam int NODE_IDX_W = 12;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 12;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_OPEN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_QUEUE  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_QUEUE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_NODE,
    S_LINK,
    S_OUT
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic look;
    logic node;
    logic link;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic go_node;
    logic go_link;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/linked_multi_queue_manager_core.sv -----
// Linked multi-queue manager: FIFO queues sharing one pool of linked nodes.
// Input channel (in_valid/in_ready): one command per transaction with
// in_mode (open, close, push, peek, pop, count), in_queue_id, in_push_value.
// Result channel (out_valid/out_ready): exactly one result per command with
// status, opened queue, node index, read data and entry count.
// One command is handled at a time. The lookup state uses the queue table
// entry read at accept; peek and pop then pass through the node state and
// push to a non-empty queue through the link state, while all other cases go
// straight to the output state. The next command is accepted only after the
// result is loaded. The extra state comes from the registered read of
// the queue table followed by a dependent read of the node memory at the
// head pointer, and from the single write port of the link memory.
// Reset empties the free list, restarts fresh node allocation at node 1 and
// marks every queue inactive; node memories need no clearing.
// If the receiver stalls, the result in the output register holds and the
// next finished result waits in the result registers before it is loaded.
module linked_multi_queue_manager_core import lmqm_pkg::*; #(
  parameter int NODE_COUNT  = 4096,
  parameter int QUEUE_COUNT = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [QID_W-1:0]        in_queue_id,
  input  logic signed [VAL_W-1:0] in_push_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [QID_W-1:0]        out_opened_queue,
  output logic [NODE_IDX_W-1:0]   out_node_index,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [COUNT_W-1:0]      out_entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lmqm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmqm_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .QUEUE_COUNT (QUEUE_COUNT),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_queue_id      (in_queue_id),
    .in_push_value    (in_push_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_opened_queue (out_opened_queue),
    .out_node_index   (out_node_index),
    .out_read_value   (out_read_value),
    .out_entry_count  (out_entry_count)
  );

endmodule

// ----- rtl/lmqm_ctrl.sv -----
module lmqm_ctrl import lmqm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (stat.go_node) begin
          state_nxt = S_NODE;
        end else if (stat.go_link) begin
          state_nxt = S_LINK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_NODE: begin
        cmd.node  = 1'b1;
        state_nxt = S_OUT;
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`include "linked_multi_queue_manager_core_assert.svh"

  `LMQM_ASSERT_NEXT(a_accept_to_look, in_valid && in_ready, state_r == S_LOOK, "no lookup")
  `LMQM_ASSERT(a_node_after_look, (state_r == S_NODE) |-> ($past(state_r) == S_LOOK), "stray node")
  `LMQM_ASSERT(a_link_after_look, (state_r == S_LINK) |-> ($past(state_r) == S_LOOK), "stray link")
  `LMQM_ASSERT_NEXT(a_out_to_idle, state_r == S_OUT && stat.out_free, state_r == S_IDLE, "stuck")

endmodule

// ----- rtl/lmqm_dp.sv -----
module lmqm_dp import lmqm_pkg::*; #(
  parameter int NODE_COUNT  = 4096,
  parameter int QUEUE_COUNT = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [QID_W-1:0]           in_queue_id,
  input  logic signed [VAL_W-1:0]    in_push_value,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [QID_W-1:0]           out_opened_queue,
  output logic [NODE_IDX_W-1:0]      out_node_index,
  output logic signed [VAL_W-1:0]    out_read_value,
  output logic [COUNT_W-1:0]         out_entry_count
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int QW = $clog2(QUEUE_COUNT);

  typedef struct packed {
    logic [NW-1:0] first;
    logic [NW-1:0] last;
    logic [NW-1:0] size;
  } qent_t;

  // Memories
  logic [NW-1:0]         link_mem [NODE_COUNT];
  logic [DATA_WIDTH-1:0] val_mem  [NODE_COUNT];
  qent_t                 q_mem    [QUEUE_COUNT];

  logic [NW-1:0]         link_rd, link_ra, link_wa, link_wd;
  logic                  link_we;
  logic [DATA_WIDTH-1:0] val_rd;
  logic [NW-1:0]         val_ra;
  logic                  val_we;
  qent_t                 q_rd, q_wd;
  logic [QW-1:0]         q_ra, q_wa;
  logic                  q_we;

  // Command and control registers
  logic [MODE_W-1:0]      mode_r;
  logic [QID_W-1:0]       qid_r;
  logic [DATA_WIDTH-1:0]  pval_r;
  logic [QUEUE_COUNT-1:0] active_r, active_nxt;
  logic [NW-1:0]          free_head_r, free_head_nxt;
  logic [NW:0]            fresh_r, fresh_nxt;
  qent_t                  qe_r;
  logic [NW-1:0]          id_r;

  // Result registers
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [QW-1:0]         res_opened_r, res_opened_nxt;
  logic [NW-1:0]         res_node_r, res_node_nxt;
  logic [DATA_WIDTH-1:0] res_value_r, res_value_nxt;
  logic [NW-1:0]         res_count_r, res_count_nxt;

  // Output register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [QW-1:0]         out_opened_r;
  logic [NW-1:0]         out_node_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic [NW-1:0]         out_count_r;

  // Decode
  logic [QW-1:0] qidx, open_idx;
  logic          open_found, q_ok, size_zero, free_nz, fresh_ok, node_avail;
  logic          is_peekpop;
  logic [NW-1:0] id_c;

  assign qidx       = QW'(qid_r);
  assign q_ok       = (qid_r != '0) && (32'(qid_r) < QUEUE_COUNT) && active_r[qidx];
  assign size_zero  = (q_rd.size == '0);
  assign free_nz    = (free_head_r != '0);
  assign fresh_ok   = (fresh_r < (NW+1)'(NODE_COUNT));
  assign node_avail = free_nz || fresh_ok;
  assign id_c       = free_nz ? free_head_r : fresh_r[NW-1:0];
  assign is_peekpop = (mode_r == MODE_PEEK) || (mode_r == MODE_POP);

  // Lowest inactive queue from 1 upward
  always_comb begin
    open_found = 1'b0;
    open_idx   = '0;
    for (int i = QUEUE_COUNT - 1; i >= 1; i--) begin
      if (!active_r[i]) begin
        open_found = 1'b1;
        open_idx   = QW'(i);
      end
    end
  end

  assign stat.go_node  = is_peekpop && q_ok && !size_zero;
  assign stat.go_link  = (mode_r == MODE_PUSH) && q_ok && node_avail && !size_zero;
  assign stat.out_free = !out_valid_r || out_ready;

  // Read addresses: queue entry and free-list link at accept, head node at lookup
  assign q_ra    = cmd.accept ? QW'(in_queue_id) : qidx;
  assign link_ra = cmd.look ? q_rd.first : free_head_r;
  assign val_ra  = q_rd.first;

  // Memory ports
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[id_c] <= pval_r;
    end
    val_rd <= val_mem[val_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_rd <= q_mem[q_ra];
  end

  // Command execution
  always_comb begin
    link_we        = 1'b0;
    link_wa        = id_c;
    link_wd        = '0;
    val_we         = 1'b0;
    q_we           = 1'b0;
    q_wa           = qidx;
    q_wd           = '0;
    active_nxt     = active_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    res_status_nxt = res_status_r;
    res_opened_nxt = res_opened_r;
    res_node_nxt   = res_node_r;
    res_value_nxt  = res_value_r;
    res_count_nxt  = res_count_r;

    if (cmd.look) begin
      res_status_nxt = STAT_OK;
      res_opened_nxt = '0;
      res_node_nxt   = '0;
      res_value_nxt  = '0;
      res_count_nxt  = '0;
      priority if (mode_r == MODE_OPEN) begin
        if (open_found) begin
          active_nxt[open_idx] = 1'b1;
          q_we           = 1'b1;
          q_wa           = open_idx;
          res_opened_nxt = open_idx;
        end else begin
          res_status_nxt = STAT_NO_QUEUE;
        end
      end else if (mode_r > MODE_COUNT || !q_ok) begin
        res_status_nxt = STAT_BAD_QUEUE;
      end else if (mode_r == MODE_CLOSE) begin
        // splice the whole list onto the free list
        if (!size_zero) begin
          link_we       = 1'b1;
          link_wa       = q_rd.last;
          link_wd       = free_head_r;
          free_head_nxt = q_rd.first;
        end
        active_nxt[qidx] = 1'b0;
        q_we             = 1'b1;
      end else if (mode_r == MODE_PUSH) begin
        if (!node_avail) begin
          res_status_nxt = STAT_EXHAUSTED;
        end else begin
          if (free_nz) begin
            free_head_nxt = link_rd;
          end else begin
            fresh_nxt = fresh_r + 1'b1;
          end
          val_we     = 1'b1;
          link_we    = 1'b1;
          q_we       = 1'b1;
          q_wd.first = size_zero ? id_c : q_rd.first;
          q_wd.last  = id_c;
          q_wd.size  = q_rd.size + 1'b1;
          res_node_nxt = id_c;
        end
      end else if (is_peekpop) begin
        if (size_zero) begin
          res_status_nxt = STAT_EMPTY;
        end
      end else begin
        res_count_nxt = q_rd.size;
      end
    end

    // old tail points at the new node
    if (cmd.link) begin
      link_we = 1'b1;
      link_wa = qe_r.last;
      link_wd = id_r;
    end

    // head node data is back; pop unlinks it
    if (cmd.node) begin
      res_node_nxt  = qe_r.first;
      res_value_nxt = val_rd;
      if (mode_r == MODE_POP) begin
        q_we      = 1'b1;
        q_wd.size = qe_r.size - 1'b1;
        if (qe_r.size == NW'(1)) begin
          q_wd.first = '0;
          q_wd.last  = '0;
        end else begin
          q_wd.first = link_rd;
          q_wd.last  = qe_r.last;
        end
        link_we       = 1'b1;
        link_wa       = qe_r.first;
        link_wd       = free_head_r;
        free_head_nxt = qe_r.first;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      free_head_r <= '0;
      fresh_r     <= (NW+1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      qid_r  <= in_queue_id;
      pval_r <= DATA_WIDTH'(in_push_value);
    end
    if (cmd.look) begin
      qe_r <= q_rd;
      id_r <= id_c;
    end
    res_status_r <= res_status_nxt;
    res_opened_r <= res_opened_nxt;
    res_node_r   <= res_node_nxt;
    res_value_r  <= res_value_nxt;
    res_count_r  <= res_count_nxt;
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_opened_r <= res_opened_r;
      out_node_r   <= res_node_r;
      out_value_r  <= res_value_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_opened_queue = QID_W'(out_opened_r);
  assign out_node_index   = NODE_IDX_W'(out_node_r);
  assign out_read_value   = VAL_W'(out_value_r);
  assign out_entry_count  = COUNT_W'(out_count_r);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lmqm_pkg::*;

  localparam int NODES   = 4096;
  localparam int QUEUES  = 64;
  localparam int WD_MAX  = 20000;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [QID_W-1:0]        qid;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [QID_W-1:0]        opened;
    logic [NODE_IDX_W-1:0]   node;
    logic signed [VAL_W-1:0] rdata;
    logic [COUNT_W-1:0]      count;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = '0;
  logic [QID_W-1:0] in_queue_id = '0;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [QID_W-1:0] out_opened_queue;
  logic [NODE_IDX_W-1:0] out_node_index;
  logic signed [VAL_W-1:0] out_read_value;
  logic [COUNT_W-1:0] out_entry_count;

  always #2 clk = ~clk;

  linked_multi_queue_manager_core u_top (.*);

  // Shadow copy of the node pool and queue table
  logic [NODE_IDX_W-1:0] link_mem [NODES];
  logic [VAL_W-1:0]      data_mem [NODES];
  logic                  q_open [QUEUES];
  logic [NODE_IDX_W-1:0] q_head [QUEUES];
  logic [NODE_IDX_W-1:0] q_tail [QUEUES];
  logic [COUNT_W-1:0]    q_len  [QUEUES];
  logic [NODE_IDX_W-1:0] free_top;
  int unsigned           fresh_idx;

  cmd_t  cmd_q[$];
  resp_t result_q[$];
  int    errors = 0;
  int    idle_in = 0, idle_out = 0;
  bit    stim_done = 0;

  task automatic pool_reset();
    for (int i = 0; i < QUEUES; i++) begin
      q_open[i] = '0; q_head[i] = '0; q_tail[i] = '0; q_len[i] = '0;
    end
    free_top = '0;
    fresh_idx = 1;
  endtask

  // Advance the shadow state for one command, return its result
  function automatic resp_t queue_mgr_step(cmd_t c);
    resp_t r;
    int i;
    logic [NODE_IDX_W-1:0] id;
    int q;
    r = '0;
    q = int'(c.qid);
    if (c.mode == MODE_OPEN) begin
      i = 1;
      while (i < QUEUES && q_open[i]) i++;
      if (i < QUEUES) begin
        q_open[i] = 1'b1; q_head[i] = '0; q_tail[i] = '0; q_len[i] = '0;
        r.opened = QID_W'(i);
      end else r.status = STAT_NO_QUEUE;
    end else if (c.mode > MODE_COUNT || q == 0 || !q_open[q]) begin
      r.status = STAT_BAD_QUEUE;
    end else if (c.mode == MODE_CLOSE) begin
      if (q_len[q] > 0) begin
        link_mem[q_tail[q]] = free_top;
        free_top = q_head[q];
      end
      q_open[q] = 1'b0; q_head[q] = '0; q_tail[q] = '0; q_len[q] = '0;
    end else if (c.mode == MODE_PUSH) begin
      id = '0;
      if (free_top != 0) begin
        id = free_top;
        free_top = link_mem[id];
      end else if (fresh_idx < NODES) begin
        id = NODE_IDX_W'(fresh_idx);
        fresh_idx++;
      end
      if (id == 0) r.status = STAT_EXHAUSTED;
      else begin
        link_mem[id] = '0;
        data_mem[id] = c.value;
        if (q_len[q] == 0) q_head[q] = id;
        else link_mem[q_tail[q]] = id;
        q_tail[q] = id;
        q_len[q]++;
        r.node = id;
      end
    end else if (c.mode == MODE_PEEK || c.mode == MODE_POP) begin
      id = q_head[q];
      if (q_len[q] == 0 || id == 0) r.status = STAT_EMPTY;
      else begin
        r.node = id;
        r.rdata = data_mem[id];
        if (c.mode == MODE_POP) begin
          q_head[q] = link_mem[id];
          q_len[q]--;
          if (q_len[q] == 0) begin
            q_head[q] = '0; q_tail[q] = '0;
          end
          link_mem[id] = free_top;
          free_top = id;
        end
      end
    end else begin
      r.count = q_len[q];
    end
    return r;
  endfunction

  function automatic cmd_t mk(int m, int q, logic [31:0] v);
    cmd_t c;
    c.mode = MODE_W'(m); c.qid = QID_W'(q); c.value = v;
    return c;
  endfunction

  // Stimulus
  initial begin
    pool_reset();
    // directed: errors on idle block, open, push extremes, peek, pop, count, close
    cmd_q.push_back(mk(MODE_PEEK, 0, 0));
    cmd_q.push_back(mk(MODE_CLOSE, 1, 0));
    cmd_q.push_back(mk(MODE_PUSH, 63, 32'hFFFF_FFFF));
    cmd_q.push_back(mk(6, 1, 0));
    cmd_q.push_back(mk(7, 63, 0));
    cmd_q.push_back(mk(MODE_OPEN, 63, 0));
    cmd_q.push_back(mk(MODE_PEEK, 1, 0));
    cmd_q.push_back(mk(MODE_POP, 1, 0));
    cmd_q.push_back(mk(MODE_PUSH, 1, 32'h8000_0000));
    cmd_q.push_back(mk(MODE_PUSH, 1, 32'h7FFF_FFFF));
    cmd_q.push_back(mk(MODE_PUSH, 1, 32'h0));
    cmd_q.push_back(mk(MODE_COUNT, 1, 0));
    cmd_q.push_back(mk(MODE_PEEK, 1, 0));
    cmd_q.push_back(mk(MODE_POP, 1, 0));
    cmd_q.push_back(mk(MODE_CLOSE, 1, 0));
    cmd_q.push_back(mk(MODE_CLOSE, 1, 0));
    cmd_q.push_back(mk(MODE_COUNT, 0, 0));
    // fill all queues, then one open too many
    for (int i = 0; i < 64; i++) cmd_q.push_back(mk(MODE_OPEN, i, 0));
    // random: mostly valid traffic on open queues
    for (int n = 0; n < 1400; n++) begin
      int r, m, q;
      r = $urandom_range(0, 99);
      q = $urandom_range(1, 12);
      if (r < 40) m = MODE_PUSH;
      else if (r < 60) m = MODE_POP;
      else if (r < 70) m = MODE_PEEK;
      else if (r < 78) m = MODE_COUNT;
      else if (r < 84) m = MODE_CLOSE;
      else if (r < 92) m = MODE_OPEN;
      else begin
        m = $urandom_range(0, 7);
        q = $urandom_range(0, 63);
      end
      cmd_q.push_back(mk(m, q, $urandom));
    end
    for (int q = 1; q < 64; q++) cmd_q.push_back(mk(MODE_CLOSE, q, 0));
    for (int n = 0; n < 20; n++) begin
      cmd_q.push_back(mk(MODE_OPEN, 0, 0));
      cmd_q.push_back(mk(MODE_PUSH, 1, $urandom));
      cmd_q.push_back(mk(MODE_POP, 1, 0));
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Idle profile changes with the remaining stimulus
  function automatic void pick_idle(int left);
    int ph;
    ph = (left / 400) % 4;
    idle_in  = (ph == 1) ? 64 : (ph == 3) ? 35 : 0;
    idle_out = (ph == 2) ? 64 : (ph == 3) ? 35 : 0;
  endfunction

  // accepted flag from the preceding rising edge
  logic in_ready_seen = 1'b0;

  // Driver
  always @(negedge clk) begin
    if (rst_n) begin
      pick_idle(cmd_q.size());
      out_ready <= ($urandom_range(0, 99) >= idle_out);
      if (!in_valid || in_ready_seen) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_in) begin
          cmd_t c;
          c = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= c.mode;
          in_queue_id <= c.qid;
          in_push_value <= c.value;
        end else begin
          in_valid <= 1'b0;
          if (cmd_q.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor and checker
  int wd = 0;
  always @(posedge clk) begin
    resp_t exp_r;
    logic  acc_in, acc_out;
    acc_in  = in_valid && in_ready;
    acc_out = out_valid && out_ready;
    in_ready_seen <= rst_n && acc_in;
    if (rst_n) begin
      wd <= (acc_in || acc_out) ? 0 : wd + 1;
      if (acc_in) begin
        result_q.push_back(queue_mgr_step(mk(int'(in_mode), int'(in_queue_id),
                                             in_push_value)));
      end
      if (acc_out) begin
        if (result_q.size() == 0) begin
          $error("result with no command pending");
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, out_status); errors++;
          end
          if (out_opened_queue !== exp_r.opened) begin
            $error("opened_queue exp %0d got %0d", exp_r.opened, out_opened_queue);
            errors++;
          end
          if (out_node_index !== exp_r.node) begin
            $error("node_index exp %0d got %0d", exp_r.node, out_node_index); errors++;
          end
          if (out_read_value !== exp_r.rdata) begin
            $error("read_value exp %0d got %0d", exp_r.rdata, out_read_value); errors++;
          end
          if (out_entry_count !== exp_r.count) begin
            $error("entry_count exp %0d got %0d", exp_r.count, out_entry_count);
            errors++;
          end
        end
      end
      if (wd >= WD_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done && !in_valid);
    wait (result_q.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- linked_multi_queue_manager_core.f -----
+incdir+rtl
rtl/lmqm_pkg.sv
rtl/lmqm_ctrl.sv
rtl/lmqm_dp.sv
rtl/linked_multi_queue_manager_core.sv
tb/sv/testbench.sv
